### rtl/core/vrt_pkg.sv
// ----------------------------------------------------------------------------
// Vibration RMS tracker package
// Shared widths, register indexes, reset values, and the command and status
// types that join the controller to the datapath.
// ----------------------------------------------------------------------------
package vrt_pkg;

    // Field and internal widths.
    localparam int AXIS_W     = 16;
    localparam int OUT_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = 32;
    localparam int OPB_W      = 32;
    localparam int PROD_W     = CFG_W + OPB_W;
    localparam int STEP_CNT_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LEVEL       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_WEIGHT = 2'd1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] REST_LEVEL_RST       = 16'd8192;
    localparam logic [CFG_W-1:0] SMOOTHING_WEIGHT_RST = 16'd3277;

    // Starting step index of the square root, counted down to zero (one result bit per step).
    localparam logic [STEP_CNT_W-1:0] ROOT_LAST_STEP = 4'd15;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SQ_X,
        CMD_SQ_Y,
        CMD_SQ_Z,
        CMD_ACC,
        CMD_ROOT_MAG,
        CMD_ROOT_STEP,
        CMD_DEV,
        CMD_SQ_DEV,
        CMD_DIFF,
        CMD_STEP_MUL,
        CMD_UPDATE,
        CMD_ROOT_MEAN,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        t_cmd op;
    } t_dp_cmd;

    typedef struct packed {
        logic root_last;
    } t_dp_status;

endpackage

### rtl/core/vrt_ctrl.sv
// ----------------------------------------------------------------------------
// Vibration RMS tracker controller
// Sequences one sample through squaring, the magnitude root, the mean update
// and the RMS root, and owns both handshakes of the data channels.
// ----------------------------------------------------------------------------
module vrt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vrt_pkg::t_dp_cmd    o_cmd,
    input  vrt_pkg::t_dp_status i_status
);
    import vrt_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE          = 15'b000000000000001,
        S_SQ_X          = 15'b000000000000010,
        S_SQ_Y          = 15'b000000000000100,
        S_SQ_Z          = 15'b000000000001000,
        S_ACC           = 15'b000000000010000,
        S_ROOT_MAG      = 15'b000000000100000,
        S_ROOT_MAG_RUN  = 15'b000000001000000,
        S_DEV           = 15'b000000010000000,
        S_SQ_DEV        = 15'b000000100000000,
        S_DIFF          = 15'b000001000000000,
        S_STEP          = 15'b000010000000000,
        S_UPDATE        = 15'b000100000000000,
        S_ROOT_MEAN     = 15'b001000000000000,
        S_ROOT_MEAN_RUN = 15'b010000000000000,
        S_EMIT          = 15'b100000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Next state, datapath command and output slot.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd.op    = CMD_NONE;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = CMD_LOAD;
                    n_state  = S_SQ_X;
                end
            end
            S_SQ_X: begin
                o_cmd.op = CMD_SQ_X;
                n_state  = S_SQ_Y;
            end
            S_SQ_Y: begin
                o_cmd.op = CMD_SQ_Y;
                n_state  = S_SQ_Z;
            end
            S_SQ_Z: begin
                o_cmd.op = CMD_SQ_Z;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = CMD_ACC;
                n_state  = S_ROOT_MAG;
            end
            S_ROOT_MAG: begin
                o_cmd.op = CMD_ROOT_MAG;
                n_state  = S_ROOT_MAG_RUN;
            end
            S_ROOT_MAG_RUN: begin
                o_cmd.op = CMD_ROOT_STEP;
                if (i_status.root_last) begin
                    n_state = S_DEV;
                end
            end
            S_DEV: begin
                o_cmd.op = CMD_DEV;
                n_state  = S_SQ_DEV;
            end
            S_SQ_DEV: begin
                o_cmd.op = CMD_SQ_DEV;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.op = CMD_DIFF;
                n_state  = S_STEP;
            end
            S_STEP: begin
                o_cmd.op = CMD_STEP_MUL;
                n_state  = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.op = CMD_UPDATE;
                n_state  = S_ROOT_MEAN;
            end
            S_ROOT_MEAN: begin
                o_cmd.op = CMD_ROOT_MEAN;
                n_state  = S_ROOT_MEAN_RUN;
            end
            S_ROOT_MEAN_RUN: begin
                o_cmd.op = CMD_ROOT_STEP;
                if (i_status.root_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Wait here until the output register has room for the beat.
                if (w_slot_free) begin
                    o_cmd.op    = CMD_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/core/vrt_datapath.sv
// ----------------------------------------------------------------------------
// Vibration RMS tracker datapath
// Configuration registers, one shared 16x32 multiplier, a one-bit-per-cycle
// square root unit, the running mean square and the output payload register.
// ----------------------------------------------------------------------------
module vrt_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [vrt_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic signed [vrt_pkg::AXIS_W-1:0]      i_accel_x,
    input  logic signed [vrt_pkg::AXIS_W-1:0]      i_accel_y,
    input  logic signed [vrt_pkg::AXIS_W-1:0]      i_accel_z,
    input  vrt_pkg::t_dp_cmd                       i_cmd,
    output vrt_pkg::t_dp_status                    o_status,
    output logic [vrt_pkg::OUT_W-1:0]              o_rms_level,
    output logic [vrt_pkg::OUT_W-1:0]              o_deviation
);
    import vrt_pkg::*;

    // Configuration.
    logic [CFG_W-1:0]      r_rest_level;
    logic [CFG_W-1:0]      r_weight;

    // Sample and arithmetic state.
    logic [AXIS_W-1:0]     r_abs_x;
    logic [AXIS_W-1:0]     r_abs_y;
    logic [AXIS_W-1:0]     r_abs_z;
    logic [SUM_W-1:0]      r_acc;
    logic [PROD_W-1:0]     r_prod;
    logic [OUT_W-1:0]      r_dev;
    logic [SUM_W-1:0]      r_diff;
    logic                  r_up;
    logic [SUM_W-1:0]      r_mean;

    // Square root unit.
    logic [SUM_W-1:0]      r_rem;
    logic [SUM_W-1:0]      r_root;
    logic [STEP_CNT_W-1:0] r_step;
    logic [SUM_W-1:0]      w_bit;
    logic [SUM_W:0]        w_trial;
    logic                  w_take;

    // Output payload.
    logic [OUT_W-1:0]      r_rms_out;
    logic [OUT_W-1:0]      r_dev_out;

    // Shared multiplier operands.
    logic [CFG_W-1:0]      w_mul_a;
    logic [OPB_W-1:0]      w_mul_b;
    logic [PROD_W-1:0]     w_mul_p;

    // Magnitude against rest level, and the mean square update step.
    logic [OUT_W-1:0]      w_mag;
    logic [SUM_W-1:0]      w_d2;
    logic [SUM_W-1:0]      w_step;
    logic [OUT_W-1:0]      w_rms_sat;

    function automatic logic [AXIS_W-1:0] abs16(input logic signed [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] u;
        u = v;
        return v[AXIS_W-1] ? (~u + 1'b1) : u;
    endfunction

    assign w_bit   = {{(SUM_W-1){1'b0}}, 1'b1} << {r_step, 1'b0};
    assign w_trial = {1'b0, r_root} + {1'b0, w_bit};
    assign w_take  = ({1'b0, r_rem} >= w_trial);
    assign o_status.root_last = (r_step == '0);

    assign w_mag     = r_root[OUT_W-1:0];
    assign w_d2      = r_prod[SUM_W-1:0];
    assign w_step    = r_prod[PROD_W-1:CFG_W];
    assign w_rms_sat = (|r_root[SUM_W-1:OUT_W]) ? {OUT_W{1'b1}} : r_root[OUT_W-1:0];

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            CMD_SQ_X: begin
                w_mul_a = r_abs_x;
                w_mul_b = {{(OPB_W-AXIS_W){1'b0}}, r_abs_x};
            end
            CMD_SQ_Y: begin
                w_mul_a = r_abs_y;
                w_mul_b = {{(OPB_W-AXIS_W){1'b0}}, r_abs_y};
            end
            CMD_SQ_Z: begin
                w_mul_a = r_abs_z;
                w_mul_b = {{(OPB_W-AXIS_W){1'b0}}, r_abs_z};
            end
            CMD_SQ_DEV: begin
                w_mul_a = r_dev;
                w_mul_b = {{(OPB_W-OUT_W){1'b0}}, r_dev};
            end
            CMD_STEP_MUL: begin
                w_mul_a = r_weight;
                w_mul_b = r_diff;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // Config regs; the user writes only while the block is idle; unenforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_level <= REST_LEVEL_RST;
            r_weight     <= SMOOTHING_WEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REST_LEVEL:       r_rest_level <= i_cfg_data;
                CFG_SMOOTHING_WEIGHT: r_weight     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The running mean square is the only state that reset must clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
        end else if (i_cmd.op == CMD_UPDATE) begin
            r_mean <= r_up ? (r_mean + w_step) : (r_mean - w_step);
        end
    end

    // Working registers, stepped by the controller's commands.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_LOAD: begin
                r_abs_x <= abs16(i_accel_x);
                r_abs_y <= abs16(i_accel_y);
                r_abs_z <= abs16(i_accel_z);
                r_acc   <= '0;
            end
            CMD_SQ_X: begin
                r_prod <= w_mul_p;
            end
            CMD_SQ_Y, CMD_SQ_Z: begin
                r_prod <= w_mul_p;
                r_acc  <= r_acc + w_d2;
            end
            CMD_ACC: begin
                r_acc <= r_acc + w_d2;
            end
            CMD_ROOT_MAG: begin
                r_rem  <= r_acc;
                r_root <= '0;
                r_step <= ROOT_LAST_STEP;
            end
            CMD_ROOT_MEAN: begin
                r_rem  <= r_mean;
                r_root <= '0;
                r_step <= ROOT_LAST_STEP;
            end
            CMD_ROOT_STEP: begin
                // One result bit per cycle, from the top bit down.
                if (w_take) begin
                    r_rem  <= r_rem - w_trial[SUM_W-1:0];
                    r_root <= (r_root >> 1) + w_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_step <= r_step - 1'b1;
            end
            CMD_DEV: begin
                r_dev <= (w_mag >= r_rest_level) ? (w_mag - r_rest_level)
                                                 : (r_rest_level - w_mag);
            end
            CMD_SQ_DEV, CMD_STEP_MUL: begin
                r_prod <= w_mul_p;
            end
            CMD_DIFF: begin
                r_up   <= (w_d2 >= r_mean);
                r_diff <= (w_d2 >= r_mean) ? (w_d2 - r_mean) : (r_mean - w_d2);
            end
            CMD_EMIT: begin
                r_rms_out <= w_rms_sat;
                r_dev_out <= r_dev;
            end
            default: begin
            end
        endcase
    end

    assign o_rms_level = r_rms_out;
    assign o_deviation = r_dev_out;

endmodule

### rtl/core/vibration_rms_tracker_unit.sv
// ----------------------------------------------------------------------------
// Vibration RMS tracker
// Three-axis accelerometer samples in; running RMS of the deviation of the
// vector magnitude from a rest level, and that deviation, out.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+-------------------------------------
//  in       | i_in_valid  / o_in_ready     | i_accel_x, i_accel_y, i_accel_z
//  out      | o_out_valid / i_out_ready    | o_rms_level, o_deviation
//  cfg      | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// From accept to result a sample goes through the three axis squares on the
// shared multiplier and one more step to finish their sum, two 16-step square
// roots on the shared root unit, and the mean update on the same multiplier.
// The next sample is taken after that. Reset is synchronous and active low; it
// restores the rest level and weight and clears the mean square. A stalled
// output beat holds in the output register while the next sample is processed;
// the result of that sample then waits until the register frees. Configuration
// beats are always accepted.
// ----------------------------------------------------------------------------
module vibration_rms_tracker_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [vrt_pkg::AXIS_W-1:0]  i_accel_x,
    input  logic signed [vrt_pkg::AXIS_W-1:0]  i_accel_y,
    input  logic signed [vrt_pkg::AXIS_W-1:0]  i_accel_z,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [vrt_pkg::OUT_W-1:0]          o_rms_level,
    output logic [vrt_pkg::OUT_W-1:0]          o_deviation,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vrt_pkg::CFG_W-1:0]          i_cfg_data
);
    import vrt_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    vrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Arithmetic and storage.
    vrt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_rms_level (o_rms_level),
        .o_deviation (o_deviation)
    );

endmodule
